>>> hdl/utf8v_pkg.sv
// ----------------------------------------------------------------------------
// utf8v_pkg
// Shared types, codes and byte decoders for the UTF-8 text validator.
// ----------------------------------------------------------------------------
package utf8v_pkg;

   localparam int unsigned ByteWidth    = 8;
   localparam int unsigned StatusWidth  = 2;
   localparam int unsigned PendingWidth = 3;
   localparam int unsigned PosWidth     = 2;

   // Result status, also used as the latched error code (VALID = no error)
   typedef enum logic [StatusWidth-1:0] {
      STATUS_VALID     = 2'd0,
      STATUS_BAD_LEAD  = 2'd1,
      STATUS_BAD_CONT  = 2'd2,
      STATUS_TRUNCATED = 2'd3
   } status_type;

   typedef struct packed {
      status_type               status;
      logic [PendingWidth-1:0]  missing_bytes;
      logic                     bom_found;
   } result_type;

   localparam logic [PendingWidth-1:0] LeadBad = 3'd7;
   localparam logic [PosWidth-1:0]     PosFull = 2'd3;

   // Continuation bytes demanded by a lead byte, LeadBad for an illegal lead
   function automatic logic [PendingWidth-1:0] lead_length(
      input logic [ByteWidth-1:0] b
   );
      logic [PendingWidth-1:0] n;
      if (b[7] == 1'b0)              n = 3'd0;
      else if (b[7:5] == 3'b110)     n = 3'd1;
      else if (b[7:4] == 4'b1110)    n = 3'd2;
      else if (b[7:3] == 5'b11110)   n = 3'd3;
      else if (b[7:2] == 6'b111110)  n = 3'd4;
      else if (b[7:1] == 7'b1111110) n = 3'd5;
      else                           n = LeadBad;
      return n;
   endfunction

   // Expected byte of the EF BB BF mark at a given position
   function automatic logic [ByteWidth-1:0] bom_byte(input logic [PosWidth-1:0] pos);
      logic [ByteWidth-1:0] v;
      unique case (pos)
         2'd0:    v = 8'hEF;
         2'd1:    v = 8'hBB;
         2'd2:    v = 8'hBF;
         default: v = 8'h00;
      endcase
      return v;
   endfunction

endpackage

>>> hdl/utf8_text_validator_top.sv
// ----------------------------------------------------------------------------
// utf8_text_validator_top
// Checks zero-terminated byte strings for (six-byte form) UTF-8 structure.
// ----------------------------------------------------------------------------
// A terminator is held in the input register, then scanned into the result register.
// Throughput: one byte per cycle, unless a terminator is held because a result
// is still waiting downstream; that stall also holds the bytes behind it.
// Reset (synchronous, active high) empties both item registers and returns
// the scan state to the start of a string.
// ----------------------------------------------------------------------------
module utf8_text_validator_top (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [utf8v_pkg::ByteWidth-1:0]    req_text_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [utf8v_pkg::StatusWidth-1:0]  rsp_status,
   output logic [utf8v_pkg::PendingWidth-1:0] rsp_missing_bytes,
   output logic                               rsp_bom_found
);

   // input register: one byte waiting to be scanned
   logic                              in_valid_ff, in_valid_in;
   logic [utf8v_pkg::ByteWidth-1:0]   in_byte_ff,  in_byte_in;

   logic                   in_is_term;
   logic                   advance;     // scan the held byte this cycle
   logic                   req_fire;
   utf8v_pkg::result_type  scan_result;
   utf8v_pkg::result_type  rsp_data;

   assign in_is_term = (in_byte_ff == '0);

   // A plain byte only updates state; a terminator also needs the result slot.
   assign advance  = in_valid_ff && (!in_is_term || !rsp_valid || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign req_fire  = req_valid && req_ready;

   always_comb begin
      in_valid_in = in_valid_ff;
      in_byte_in  = in_byte_ff;
      if (req_fire) begin
         in_valid_in = 1'b1;
         in_byte_in  = req_text_byte;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) in_valid_ff <= 1'b0;
      else       in_valid_ff <= in_valid_in;
   end

   always_ff @(posedge clock) begin
      in_byte_ff <= in_byte_in;
   end

   // scan state and per-byte update
   utf8v_check u_check (
      .clock     (clock),
      .reset     (reset),
      .step      (advance),
      .text_byte (in_byte_ff),
      .result    (scan_result)
   );

   // result register; loads only on a scanned terminator
   utf8v_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .load      (advance && in_is_term),
      .load_data (scan_result),
      .take      (rsp_ready),
      .valid     (rsp_valid),
      .data      (rsp_data)
   );

   assign rsp_status        = rsp_data.status;
   assign rsp_missing_bytes = rsp_data.missing_bytes;
   assign rsp_bom_found     = rsp_data.bom_found;

   // ---- checks ----

   // a mark-led string always reports clean
   a_bom_is_valid: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_bom_found |-> rsp_status == utf8v_pkg::STATUS_VALID)
      else $error("BOM result with non-valid status");

   // missing count only accompanies truncation, and then lies in 1..5
   a_missing_consistent: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_status == utf8v_pkg::STATUS_TRUNCATED)
                     ? (rsp_missing_bytes != 3'd0 && rsp_missing_bytes <= 3'd5)
                     : (rsp_missing_bytes == 3'd0)))
      else $error("missing_bytes inconsistent with status");

   // input stalls only behind a terminator blocked by a full result slot
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> in_valid_ff && in_is_term && rsp_valid && !rsp_ready)
      else $error("input stalled without a blocked terminator");

   // a result is produced only by a terminator scanned in the prior cycle
   a_rsp_source: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(advance && in_is_term))
      else $error("result appeared without a terminator");

endmodule

>>> hdl/utf8v_check.sv
// ----------------------------------------------------------------------------
// utf8v_check
// Per-string scan state and its registered update for one byte.
// ----------------------------------------------------------------------------
module utf8v_check (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  step,
   input  logic [utf8v_pkg::ByteWidth-1:0]       text_byte,
   output utf8v_pkg::result_type                 result
);

   logic                                  in_seq_ff,    in_seq_in;
   logic [utf8v_pkg::PendingWidth-1:0]    pending_ff,   pending_in;
   utf8v_pkg::status_type                 err_ff,       err_in;
   logic [utf8v_pkg::PosWidth-1:0]        pos_ff,       pos_in;
   logic                                  bom_match_ff, bom_match_in;

   logic                                  bom_seen;
   logic [utf8v_pkg::PendingWidth-1:0]    lead_n;

   assign bom_seen = bom_match_ff && (pos_ff == utf8v_pkg::PosFull);
   assign lead_n   = utf8v_pkg::lead_length(text_byte);

   // result for a terminator, taken from the state before it
   always_comb begin
      result.status        = utf8v_pkg::STATUS_VALID;
      result.missing_bytes = '0;
      result.bom_found     = 1'b0;
      if (bom_seen) begin
         result.bom_found = 1'b1;
      end else if (err_ff != utf8v_pkg::STATUS_VALID) begin
         result.status = err_ff;
      end else if (in_seq_ff) begin
         result.status        = utf8v_pkg::STATUS_TRUNCATED;
         result.missing_bytes = pending_ff;
      end
   end

   always_comb begin
      in_seq_in    = in_seq_ff;
      pending_in   = pending_ff;
      err_in       = err_ff;
      pos_in       = pos_ff;
      bom_match_in = bom_match_ff;
      if (step) begin
         if (text_byte == '0) begin
            in_seq_in    = 1'b0;
            pending_in   = '0;
            err_in       = utf8v_pkg::STATUS_VALID;
            pos_in       = '0;
            bom_match_in = 1'b1;
         end else if (!bom_seen) begin
            if (pos_ff != utf8v_pkg::PosFull) begin
               if (text_byte != utf8v_pkg::bom_byte(pos_ff)) bom_match_in = 1'b0;
               pos_in = pos_ff + 2'd1;
            end
            if (err_ff == utf8v_pkg::STATUS_VALID) begin
               if (!in_seq_ff) begin
                  if (lead_n == utf8v_pkg::LeadBad) begin
                     err_in = utf8v_pkg::STATUS_BAD_LEAD;
                  end else if (lead_n != '0) begin
                     in_seq_in  = 1'b1;
                     pending_in = lead_n;
                  end
               end else if (text_byte[7:6] == 2'b10) begin
                  pending_in = pending_ff - 3'd1;
                  if (pending_ff == 3'd1) in_seq_in = 1'b0;
               end else begin
                  err_in = utf8v_pkg::STATUS_BAD_CONT;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_seq_ff    <= 1'b0;
         pending_ff   <= '0;
         err_ff       <= utf8v_pkg::STATUS_VALID;
         pos_ff       <= '0;
         bom_match_ff <= 1'b1;
      end else begin
         in_seq_ff    <= in_seq_in;
         pending_ff   <= pending_in;
         err_ff       <= err_in;
         pos_ff       <= pos_in;
         bom_match_ff <= bom_match_in;
      end
   end

endmodule

>>> hdl/utf8v_rsp_reg.sv
// ----------------------------------------------------------------------------
// utf8v_rsp_reg
// Result register holding one finished item until the consumer takes it.
// ----------------------------------------------------------------------------
module utf8v_rsp_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  utf8v_pkg::result_type  load_data,
   input  logic                   take,
   output logic                   valid,
   output utf8v_pkg::result_type  data
);

   logic                   valid_ff, valid_in;
   utf8v_pkg::result_type  data_ff,  data_in;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = load_data;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else       valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign valid = valid_ff;
   assign data  = data_ff;

endmodule

>>> dv/tb_utf8_text_validator_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_utf8_text_validator_top
// Self-checking bench for the UTF-8 text validator: zero-terminated strings
// go in byte by byte, and each terminator's verdict is checked against a
// scan of the same bytes kept inside the bench.
// ----------------------------------------------------------------------------
module tb_utf8_text_validator_top;

   // Longest quiet stretch of a good run is the receiver hold-off (HoldCycles)
   // plus a few random stalls; the watchdog allows several times that.
   localparam int WatchdogLimit = 1000;
   localparam int HoldAt        = 80;   // bytes taken before the long hold-off
   localparam int HoldCycles    = 150;
   localparam int TailCycles    = 8;    // wait after the drain, before the summary
   localparam int TargetBytes   = 550;

   typedef struct packed {
      logic       pause;   // marker: hold the sender until all verdicts are in
      logic [7:0] value;
   } text_item_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   logic [7:0] req_text_byte = 8'h00;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   logic [1:0] rsp_status;
   logic [2:0] rsp_missing_bytes;
   logic       rsp_bom_found;

   text_item_type         text_q[$];       // bytes waiting to be offered
   utf8v_pkg::result_type verdict_q[$];    // verdicts owed by the block, oldest first

   // Updated only by nonblocking writes in the monitor, so the driver and
   // the receiver always see the value from before the current edge.
   int verdicts_owed = 0;
   int bytes_taken   = 0;
   int idle_cycles   = 0;

   int total_bytes = 1;
   int idle_phase;
   int send_idle_pct;
   int recv_idle_pct;

   int mismatches     = 0;
   int strings_done   = 0;
   int mark_hits      = 0;
   int verdict_hist [4];

   int hold_left = 0;
   bit hold_done = 1'b0;

   // Scan state of the bench's own copy of the validator
   logic                  scan_in_seq;
   logic [2:0]            scan_pending;
   utf8v_pkg::status_type scan_err;
   logic [1:0]            scan_pos;
   logic                  scan_mark_ok;

   utf8_text_validator_top dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_text_byte     (req_text_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_status        (rsp_status),
      .rsp_missing_bytes (rsp_missing_bytes),
      .rsp_bom_found     (rsp_bom_found)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Idle mix follows progress: sender 29 / receiver 73, then swapped, then none
   assign idle_phase    = (bytes_taken * 3) / total_bytes;
   assign send_idle_pct = (idle_phase == 0) ? 29 : (idle_phase == 1) ? 73 : 0;
   assign recv_idle_pct = (idle_phase == 0) ? 73 : (idle_phase == 1) ? 29 : 0;

   // ------------------------------------------------------------------------
   // Scan model
   // ------------------------------------------------------------------------
   task automatic scan_clear();
      scan_in_seq  = 1'b0;
      scan_pending = 3'd0;
      scan_err     = utf8v_pkg::STATUS_VALID;
      scan_pos     = 2'd0;
      scan_mark_ok = 1'b1;
   endtask

   // Advance the scan by one byte; a zero byte yields the string's verdict.
   task automatic scan_byte(input logic [7:0] b, output bit produced,
                            output utf8v_pkg::result_type verdict);
      logic [7:0] mark_byte;
      logic       mark_done;
      produced  = 1'b0;
      verdict   = '0;
      mark_done = scan_mark_ok && (scan_pos == 2'd3);
      if (b == 8'h00) begin
         produced = 1'b1;
         verdict.status = utf8v_pkg::STATUS_VALID;
         if (mark_done) begin
            verdict.bom_found = 1'b1;
         end else if (scan_err != utf8v_pkg::STATUS_VALID) begin
            verdict.status = scan_err;
         end else if (scan_in_seq) begin
            verdict.status        = utf8v_pkg::STATUS_TRUNCATED;
            verdict.missing_bytes = scan_pending;
         end
         scan_clear();
      end else if (!mark_done) begin
         // the first three bytes are also compared against EF BB BF
         if (scan_pos != 2'd3) begin
            case (scan_pos)
               2'd0:    mark_byte = 8'hEF;
               2'd1:    mark_byte = 8'hBB;
               default: mark_byte = 8'hBF;
            endcase
            if (b != mark_byte) scan_mark_ok = 1'b0;
            scan_pos = scan_pos + 2'd1;
         end
         // once an error is latched the rest of the string is ignored
         if (scan_err == utf8v_pkg::STATUS_VALID) begin
            if (!scan_in_seq) begin
               casez (b)
                  8'b0???????: ;
                  8'b110?????: begin scan_in_seq = 1'b1; scan_pending = 3'd1; end
                  8'b1110????: begin scan_in_seq = 1'b1; scan_pending = 3'd2; end
                  8'b11110???: begin scan_in_seq = 1'b1; scan_pending = 3'd3; end
                  8'b111110??: begin scan_in_seq = 1'b1; scan_pending = 3'd4; end
                  8'b1111110?: begin scan_in_seq = 1'b1; scan_pending = 3'd5; end
                  default:     scan_err = utf8v_pkg::STATUS_BAD_LEAD;
               endcase
            end else if (b[7:6] == 2'b10) begin
               scan_pending = scan_pending - 3'd1;
               if (scan_pending == 3'd0) scan_in_seq = 1'b0;
            end else begin
               scan_err = utf8v_pkg::STATUS_BAD_CONT;
            end
         end
      end
   endtask

   // ------------------------------------------------------------------------
   // Stimulus building
   // ------------------------------------------------------------------------
   task automatic push_byte(input logic [7:0] b);
      text_item_type it;
      it.pause = 1'b0;
      it.value = b;
      text_q.push_back(it);
   endtask

   task automatic push_pause();
      text_item_type it;
      it.pause = 1'b1;
      it.value = 8'h00;
      text_q.push_back(it);
   endtask

   // Random lead byte of a sequence with cls continuation bytes (0..5)
   function automatic logic [7:0] lead_of(input int cls);
      logic [7:0] r;
      r = 8'($urandom);
      case (cls)
         0:       return 8'($urandom_range(127, 1));
         1:       return 8'hC0 | (r & 8'h1F);
         2:       return 8'hE0 | (r & 8'h0F);
         3:       return 8'hF0 | (r & 8'h07);
         4:       return 8'hF8 | (r & 8'h03);
         default: return 8'hFC | (r & 8'h01);
      endcase
   endfunction

   function automatic logic [7:0] cont_byte();
      logic [7:0] r;
      r = 8'($urandom);
      return 8'h80 | (r & 8'h3F);
   endfunction

   // Nonzero byte that is not of the form 10xxxxxx
   function automatic logic [7:0] bad_cont_byte();
      logic [7:0] r;
      r = 8'($urandom_range(255, 1));
      if (r[7:6] == 2'b10) r[6] = 1'b1;
      return r;
   endfunction

   // Continuation pattern, FE or FF, all illegal as a lead
   function automatic logic [7:0] bad_lead_byte();
      case ($urandom_range(3))
         0:       return 8'hFE;
         1:       return 8'hFF;
         default: return cont_byte();
      endcase
   endfunction

   function automatic int pick_class();
      int c;
      c = $urandom_range(9);
      return (c > 5) ? 0 : c;
   endfunction

   task automatic push_char(input int cls);
      push_byte(lead_of(cls));
      for (int k = 0; k < cls; k++) push_byte(cont_byte());
   endtask

   // One string: well-formed text, some with a planted fault, some
   // starting with the mark or a prefix of it, and some plain noise.
   task automatic push_random_string();
      int mode, n_chars, fault, fault_at, cls, good;
      mode     = $urandom_range(99);
      n_chars  = $urandom_range(6);
      fault    = $urandom_range(99);
      fault_at = $urandom_range(n_chars);
      if (mode < 8) begin
         push_byte(8'hEF); push_byte(8'hBB); push_byte(8'hBF);
         for (int i = 0; i < n_chars; i++) push_byte(8'($urandom_range(255, 1)));
      end else if (mode < 14) begin
         push_byte(8'hEF);
         if ($urandom_range(1) == 1) push_byte(8'hBB);
         for (int i = 0; i < n_chars; i++) push_char(pick_class());
      end else if (mode < 24) begin
         for (int i = 0; i < n_chars; i++) push_byte(8'($urandom_range(255, 1)));
      end else begin
         for (int i = 0; i <= n_chars; i++) begin
            if (i == fault_at && fault >= 55) begin
               cls  = $urandom_range(5, 1);
               good = $urandom_range(cls - 1);
               if (fault < 70) begin
                  push_byte(bad_lead_byte());
               end else if (fault < 85) begin
                  push_byte(lead_of(cls));
                  for (int k = 0; k < good; k++) push_byte(cont_byte());
                  push_byte(bad_cont_byte());
               end else begin
                  // cut the string short inside a sequence
                  push_byte(lead_of(cls));
                  for (int k = 0; k < good; k++) push_byte(cont_byte());
                  break;
               end
            end else if (i < n_chars) begin
               push_char(pick_class());
            end
         end
      end
      push_byte(8'h00);
   endtask

   // ------------------------------------------------------------------------
   // Driver: offers bytes from text_q; a pause marker holds it until the
   // block owes nothing.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : driver
      text_item_type nxt;
      if (reset) begin
         req_valid     <= 1'b0;
         req_text_byte <= 8'h00;
      end else if (!req_valid || req_ready) begin
         if (text_q.size() != 0 && text_q[0].pause) begin
            req_valid <= 1'b0;
            // with valid low at this edge, verdicts_owed covers every byte taken
            if (!req_valid && verdicts_owed == 0) void'(text_q.pop_front());
         end else if (text_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
            nxt = text_q.pop_front();
            req_valid     <= 1'b1;
            req_text_byte <= nxt.value;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Receiver: random ready, plus one long hold-off early in the run so that
   // terminators back up and the block stops taking bytes.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
         hold_done <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (!hold_done && bytes_taken >= HoldAt) begin
         rsp_ready <= 1'b0;
         hold_left <= HoldCycles;
         hold_done <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // ------------------------------------------------------------------------
   // Monitor: scans each byte taken, checks each verdict delivered, and
   // keeps the watchdog.
   // ------------------------------------------------------------------------
   always @(posedge clock) begin : monitor
      utf8v_pkg::result_type want;
      utf8v_pkg::result_type predicted;
      bit                    produced;
      int                    owed_delta;
      if (reset) begin
         scan_clear();
         verdicts_owed <= 0;
         bytes_taken   <= 0;
         idle_cycles   <= 0;
      end else begin
         owed_delta = 0;
         if (rsp_valid && rsp_ready) begin
            if (verdict_q.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("[%0t] unexpected verdict: status=%0d missing=%0d bom=%0d",
                           $time, rsp_status, rsp_missing_bytes, rsp_bom_found);
            end else begin
               want = verdict_q.pop_front();
               owed_delta--;
               strings_done++;
               verdict_hist[want.status]++;
               if (want.bom_found) mark_hits++;
               if (rsp_status !== want.status || rsp_missing_bytes !== want.missing_bytes
                   || rsp_bom_found !== want.bom_found) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display({"[%0t] verdict mismatch: expected status=%0d missing=%0d ",
                               "bom=%0d, got status=%0d missing=%0d bom=%0d"},
                              $time, want.status, want.missing_bytes, want.bom_found,
                              rsp_status, rsp_missing_bytes, rsp_bom_found);
               end
            end
         end
         if (req_valid && req_ready) begin
            scan_byte(req_text_byte, produced, predicted);
            if (produced) begin
               verdict_q.push_back(predicted);
               owed_delta++;
            end
            bytes_taken <= bytes_taken + 1;
         end
         verdicts_owed <= verdicts_owed + owed_delta;

         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WatchdogLimit) begin
            $display("[%0t] watchdog: no handshake for %0d cycles", $time, idle_cycles);
            $display("FAIL utf8_text_validator_top");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   // ------------------------------------------------------------------------
   // Test sequence
   // ------------------------------------------------------------------------
   initial begin
      // empty string
      push_byte(8'h00);
      // full mark, then a byte that would be illegal is ignored
      push_byte(8'hEF); push_byte(8'hBB); push_byte(8'hBF); push_byte(8'hFF);
      push_byte(8'h00);
      // mark prefix cut short: checked as plain text, one byte missing
      push_byte(8'hEF); push_byte(8'hBB); push_byte(8'h00);
      // largest single byte character
      push_byte(8'h7F); push_byte(8'h00);
      // six-byte lead cut off after one continuation
      push_byte(8'hFD); push_byte(8'h80); push_byte(8'h00);
      // illegal leads: FF, a continuation pattern, FE
      push_byte(8'hFF); push_byte(8'h41); push_byte(8'h00);
      push_byte(8'h80); push_byte(8'h00);
      push_byte(8'hFE); push_byte(8'h00);
      // continuation expected, plain ASCII found
      push_byte(8'hE0); push_byte(8'h41); push_byte(8'h00);
      push_pause();

      while (text_q.size() < TargetBytes / 2) push_random_string();
      push_pause();
      while (text_q.size() < TargetBytes) push_random_string();
      total_bytes = text_q.size() - 2;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // drain: sampled away from the active edge
      @(negedge clock);
      while (text_q.size() != 0 || req_valid || verdicts_owed != 0) @(negedge clock);
      repeat (TailCycles) @(posedge clock);

      $display("Checked %0d strings over %0d bytes: %0d valid (%0d by mark), %0d bad lead,",
               strings_done, bytes_taken, verdict_hist[utf8v_pkg::STATUS_VALID], mark_hits,
               verdict_hist[utf8v_pkg::STATUS_BAD_LEAD]);
      $display("%0d bad continuation, %0d truncated; mismatches: %0d",
               verdict_hist[utf8v_pkg::STATUS_BAD_CONT],
               verdict_hist[utf8v_pkg::STATUS_TRUNCATED], mismatches);
      if (mismatches == 0)
         $display("PASS utf8_text_validator_top");
      else
         $display("FAIL utf8_text_validator_top");
      $finish;
   end

endmodule

>>> files.f
hdl/utf8v_pkg.sv
hdl/utf8v_check.sv
hdl/utf8v_rsp_reg.sv
hdl/utf8_text_validator_top.sv
dv/tb_utf8_text_validator_top.sv
